// ===== rtl/mebc_pkg.sv =====
// Shared types and the control program for the middle-ear biquad cascade.
// Holds the control-word layout, the sequencer state type and the microcode ROM.
// No dependencies.
package mebc_pkg;

	// step counter width of the microcode ROM
	localparam int unsigned STEP_W = 4;

	// operand that feeds the multiplier beside the coefficient
	typedef enum logic [2:0] {
		OPND_CUR = 3'd0,  // current section input
		OPND_P1  = 3'd1,  // previous input
		OPND_P2  = 3'd2,  // input before that
		OPND_H0  = 3'd3,  // previous section output
		OPND_H1  = 3'd4   // section output before that
	} opnd_t;

	// sequencing at the end of a step
	typedef enum logic [1:0] {
		JMP_NONE = 2'd0,  // go to next step
		JMP_SECT = 2'd1,  // loop to target while sections remain
		JMP_END  = 2'd2   // program done, back to idle
	} jmp_t;

	// one microcode word
	typedef struct packed {
		logic              mul;       // issue coef * operand
		opnd_t             opnd;
		logic [2:0]        coef_off;  // word offset inside the section
		logic              first;     // accumulator starts from the rounding term
		logic              sub;       // subtract product
		logic              wb;        // close section: round, clamp, update history
		logic              out;       // final scale result to output register
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} ctl_t;

	// word plus strobe from the sequencer to the datapath
	typedef struct packed {
		ctl_t word;
		logic fire;  // word executes this cycle
	} step_ctl_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} seq_state_t;

	// control program: five products per section, a slot for the last product
	// to land, section close with loop, then the output scale product
	function automatic ctl_t mebc_rom(input logic [STEP_W-1:0] step);
		ctl_t w;
		w = '{mul: 1'b0, opnd: OPND_CUR, coef_off: 3'd0, first: 1'b0, sub: 1'b0,
			wb: 1'b0, out: 1'b0, jmp: JMP_NONE, target: '0};
		unique case (step)
			4'd0: begin
				w.mul = 1'b1; w.opnd = OPND_CUR; w.coef_off = 3'd0; w.first = 1'b1;
			end
			4'd1: begin
				w.mul = 1'b1; w.opnd = OPND_P1; w.coef_off = 3'd1;
			end
			4'd2: begin
				w.mul = 1'b1; w.opnd = OPND_P2; w.coef_off = 3'd2;
			end
			4'd3: begin
				w.mul = 1'b1; w.opnd = OPND_H0; w.coef_off = 3'd3; w.sub = 1'b1;
			end
			4'd4: begin
				w.mul = 1'b1; w.opnd = OPND_H1; w.coef_off = 3'd4; w.sub = 1'b1;
			end
			4'd5: begin
			end
			4'd6: begin
				w.wb = 1'b1; w.jmp = JMP_SECT; w.target = 4'd0;
			end
			4'd7: begin
				w.mul = 1'b1; w.opnd = OPND_CUR; w.coef_off = 3'd0; w.first = 1'b1;
			end
			4'd8: begin
			end
			4'd9: begin
				w.out = 1'b1; w.jmp = JMP_END;
			end
			default: begin
				w.jmp = JMP_END;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/mebc_seq.sv =====
// Microcode sequencer: step counter, ROM lookup, section loop counter.
// Depends on mebc_pkg for the control word and state types.
module mebc_seq #(
	parameter int SECTIONS = 3,
	parameter int SEC_W    = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,     // sample transaction accepted
	input  logic                  out_busy,  // output register still full
	output logic                  busy,
	output mebc_pkg::step_ctl_t   ctl,
	output logic [SEC_W-1:0]      sec
);
	import mebc_pkg::*;

	seq_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	ctl_t              word;
	logic              fire;

	// state, step and section registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			sec_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sec_q   <= sec_d;
		end
	end

	// next step: at the output step, hold while the output register is full; else follow the jump field
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		sec_d   = sec_q;
		word    = mebc_rom(step_q);
		fire    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
					step_d  = '0;
					sec_d   = '0;
				end
			end
			ST_RUN: begin
				if (!(word.out && out_busy)) begin
					fire = 1'b1;
					unique case (word.jmp)
						JMP_SECT: begin
							if (sec_q != SEC_W'(SECTIONS - 1)) begin
								step_d = word.target;
								sec_d  = sec_q + 1'b1;
							end else begin
								step_d = step_q + 1'b1;
							end
						end
						JMP_END: begin
							state_d = ST_IDLE;
							step_d  = '0;
						end
						default: begin
							step_d = step_q + 1'b1;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy      = (state_q == ST_RUN);
	assign ctl.word  = word;
	assign ctl.fire  = fire;
	assign sec       = sec_q;

endmodule

// ===== rtl/mebc_dp.sv =====
// Datapath: coefficient store, filter histories, one multiplier, 64-bit accumulator,
// section rounding/clamping and the saturating output register.
// Depends on mebc_pkg for the control word types.
module mebc_dp #(
	parameter int SECTIONS    = 3,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 24,
	parameter int SEC_W       = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mebc_pkg::step_ctl_t           ctl,
	input  logic [SEC_W-1:0]              sec,
	input  logic                          start,       // sample transaction accepted
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          coef_wr,     // coefficient transaction accepted
	input  logic [3:0]                    coef_index,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [SAMPLE_BITS-1:0]        sample_out,
	output logic                          saturated
);
	import mebc_pkg::*;

	localparam int COEF_WORDS = 5 * SECTIONS + 1;
	localparam int CA         = $clog2(COEF_WORDS);
	localparam int CF         = COEF_BITS - 3;
	localparam int PW         = COEF_BITS + 32;
	localparam logic signed [63:0] RND  = 64'sd1 <<< (CF - 1);
	localparam logic signed [63:0] HMAX = 64'sd2147483647;
	localparam logic signed [63:0] HMIN = -64'sd2147483648;
	localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SMIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

	logic signed [COEF_BITS-1:0]   coef_q [COEF_WORDS];
	logic signed [SAMPLE_BITS-1:0] ih0_q, ih1_q;
	logic signed [31:0]            h0_q [SECTIONS];
	logic signed [31:0]            h1_q [SECTIONS];
	logic signed [31:0]            cur_q, p1_q, p2_q;
	logic [CA-1:0]                 base_q;
	logic signed [PW-1:0]          prod_s1;
	logic                          mul_s1, first_s1, sub_s1;
	logic signed [63:0]            acc_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_q;
	logic                          sat_q;

	logic [CA+3:0]                 wr_addr_w;
	logic [CA-1:0]                 rd_addr;
	logic signed [COEF_BITS-1:0]   coef_rd;
	logic signed [31:0]            opnd_val;
	logic signed [63:0]            prod_ext;
	logic signed [63:0]            shifted;
	logic signed [31:0]            y;
	logic signed [63:0]            v_sat;
	logic                          v_clip;
	logic                          mul_go, wb_go, out_go;

	assign mul_go = ctl.fire && ctl.word.mul;
	assign wb_go  = ctl.fire && ctl.word.wb;
	assign out_go = ctl.fire && ctl.word.out;

	// coefficient store, written only by coefficient transactions
	assign wr_addr_w = (CA + 4)'(coef_index);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < COEF_WORDS; k++) coef_q[k] <= '0;
		end else if (coef_wr && (int'(coef_index) < COEF_WORDS)) begin
			coef_q[wr_addr_w[CA-1:0]] <= coef_value;
		end
	end

	// operand and coefficient selection for the multiplier
	assign rd_addr = base_q + CA'(ctl.word.coef_off);
	assign coef_rd = coef_q[rd_addr];
	always_comb begin
		case (ctl.word.opnd)
			OPND_CUR: opnd_val = cur_q;
			OPND_P1:  opnd_val = p1_q;
			OPND_P2:  opnd_val = p2_q;
			OPND_H0:  opnd_val = h0_q[sec];
			OPND_H1:  opnd_val = h1_q[sec];
			default:  opnd_val = cur_q;
		endcase
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1   <= 1'b0;
			first_s1 <= 1'b0;
			sub_s1   <= 1'b0;
		end else begin
			mul_s1   <= mul_go;
			first_s1 <= ctl.word.first;
			sub_s1   <= ctl.word.sub;
		end
	end
	always_ff @(posedge clk) begin
		if (mul_go) prod_s1 <= PW'(coef_rd) * PW'(opnd_val);
	end

	// accumulate stage; the rounding term is preloaded with the first product
	assign prod_ext = 64'(prod_s1);
	always_ff @(posedge clk) begin
		if (mul_s1) begin
			if (first_s1)    acc_q <= RND + prod_ext;
			else if (sub_s1) acc_q <= acc_q - prod_ext;
			else             acc_q <= acc_q + prod_ext;
		end
	end

	// rescale and clamp to the 32-bit history range
	assign shifted = acc_q >>> CF;
	always_comb begin
		if (shifted > HMAX)      y = 32'sh7FFFFFFF;
		else if (shifted < HMIN) y = 32'sh80000000;
		else                     y = shifted[31:0];
	end

	// final saturation to the sample range
	always_comb begin
		v_clip = 1'b1;
		if (shifted > SMAX)      v_sat = SMAX;
		else if (shifted < SMIN) v_sat = SMIN;
		else begin
			v_sat  = shifted;
			v_clip = 1'b0;
		end
	end

	// filter histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ih0_q <= '0;
			ih1_q <= '0;
			for (int k = 0; k < SECTIONS; k++) begin
				h0_q[k] <= '0;
				h1_q[k] <= '0;
			end
		end else begin
			if (start) begin
				ih0_q <= sample_in;
				ih1_q <= ih0_q;
			end
			if (wb_go) begin
				h0_q[sec] <= y;
				h1_q[sec] <= h0_q[sec];
			end
		end
	end

	// section input registers and coefficient base
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q  <= 32'(sample_in);
			p1_q   <= 32'(ih0_q);
			p2_q   <= 32'(ih1_q);
			base_q <= '0;
		end else if (wb_go) begin
			cur_q  <= y;
			p1_q   <= h0_q[sec];
			p2_q   <= h1_q[sec];
			base_q <= base_q + CA'(5);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (out_go) begin
			out_q <= v_sat[SAMPLE_BITS-1:0];
			sat_q <= v_clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
	assign saturated  = sat_q;

endmodule

// ===== rtl/middle_ear_biquad_cascade.sv =====
// Top level of the middle-ear filter: a cascade of biquad sections on one shared MAC.
// Depends on mebc_pkg, mebc_seq and mebc_dp.
//
// Usage
//   Input stream (s_*): s_tuser is the op flag. op 0 carries a sample in
//   s_tdata; op 1 writes one coefficient word (index 0..5*SECTIONS-1 are
//   b0,b1,b2,a1,a2 per section, index 5*SECTIONS is the output scale) and
//   gives no result. Writes to indexes beyond the store are dropped.
//   Output stream (m_*): one transaction per sample, s_tdata-style packing,
//   m_tuser set when the output was clipped to the sample range.
//   Timing: a sample reaches the output register after, per section, five
//   products, a landing slot and a close step, then three scale steps. A new
//   sample is not taken until the last one is through; s_tready is low while
//   one is in work, not while a result waits on m_tready.
//   Stall: while a result waits on m_tready, the sequencer holds at its final step.
//   Reset: coefficients and all histories clear to zero, so outputs are zero
//   until the coefficients are loaded.
module middle_ear_biquad_cascade #(
	parameter int SECTIONS    = 3,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [SAMPLE_BITS-1:0] sample_in, then [3:0] coef_index, then coef_value, zero pad
	input  logic [((SAMPLE_BITS + 4 + COEF_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// [0] op
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// [SAMPLE_BITS-1:0] sample_out, zero pad
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// [0] saturated
	output logic m_tuser
);
	import mebc_pkg::*;

	localparam int OW    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	logic                          busy;
	logic                          take;
	logic                          start;
	logic                          coef_wr;
	step_ctl_t                     ctl;
	logic [SEC_W-1:0]              sec;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [3:0]                    coef_index;
	logic signed [COEF_BITS-1:0]   coef_value;
	logic [SAMPLE_BITS-1:0]        sample_out;
	logic                          out_valid;

	// input unpacking and transaction decode
	assign s_tready   = !busy;
	assign take       = s_tvalid && s_tready;
	assign start      = take && !s_tuser;
	assign coef_wr    = take && s_tuser;
	assign sample_in  = s_tdata[SAMPLE_BITS-1:0];
	assign coef_index = s_tdata[SAMPLE_BITS+3:SAMPLE_BITS];
	assign coef_value = s_tdata[SAMPLE_BITS+4+COEF_BITS-1:SAMPLE_BITS+4];

	mebc_seq #(
		.SECTIONS (SECTIONS),
		.SEC_W    (SEC_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_busy (out_valid && !m_tready),
		.busy     (busy),
		.ctl      (ctl),
		.sec      (sec)
	);

	mebc_dp #(
		.SECTIONS    (SECTIONS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS),
		.SEC_W       (SEC_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sec        (sec),
		.start      (start),
		.sample_in  (sample_in),
		.coef_wr    (coef_wr),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_ready  (m_tready),
		.out_valid  (out_valid),
		.sample_out (sample_out),
		.saturated  (m_tuser)
	);

	// output packing
	assign m_tvalid = out_valid;
	assign m_tdata  = OW'(sample_out);

endmodule
